// File: sv/vha_pkg.sv
// ----------------------------------------------------------------------------
// vha_pkg
// Shared types and fixed field widths of the voice handle allocator.
// ----------------------------------------------------------------------------
package vha_pkg;

  localparam int HANDLE_W     = 32;
  localparam int SLOT_FIELD_W = 8;
  localparam int HGEN_W       = HANDLE_W - SLOT_FIELD_W;
  localparam int PAYLOAD_W    = 32;
  localparam int KIND_W       = 3;
  localparam int ACTIVE_W     = 8;

  typedef enum logic [KIND_W-1:0] {
    KIND_PLAY    = 3'd0,
    KIND_STOP    = 3'd1,
    KIND_QUERY   = 3'd2,
    KIND_UPDATE  = 3'd3,
    KIND_RELEASE = 3'd4
  } kind_t;

  // Write strobes for the two slot stores.
  typedef struct packed {
    logic gen_we;
    logic pay_we;
  } mem_we_t;

endpackage

// File: sv/vha_req_if.sv
// ----------------------------------------------------------------------------
// vha_req_if
// Request channel: one beat carries one voice operation.
// ----------------------------------------------------------------------------
interface vha_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] handle;
  logic [7:0]  slot_index;
  logic [31:0] payload;
  logic        source_ready;

  modport source (output valid, kind, handle, slot_index, payload, source_ready,
                  input ready);
  modport sink (input valid, kind, handle, slot_index, payload, source_ready,
                output ready);
endinterface

// File: sv/vha_rsp_if.sv
// ----------------------------------------------------------------------------
// vha_rsp_if
// Response channel: one beat carries the result of one voice operation.
// ----------------------------------------------------------------------------
interface vha_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] new_handle;
  logic        ok;
  logic [31:0] stored_payload;
  logic [7:0]  active_count;

  modport source (output valid, new_handle, ok, stored_payload, active_count,
                  input ready);
  modport sink (input valid, new_handle, ok, stored_payload, active_count,
                output ready);
endinterface

// File: sv/vha_free_find.sv
// ----------------------------------------------------------------------------
// vha_free_find
// Finds the lowest-numbered free slot in the used vector.
// ----------------------------------------------------------------------------
module vha_free_find #(
  parameter int VOICES = 32,
  parameter int IDX_W  = 5
) (
  input  logic [VOICES-1:0] used,
  output logic              found,
  output logic [IDX_W-1:0]  idx
);

  always_comb begin
    found = 1'b0;
    idx   = '0;
    // Walk downward so the lowest free slot wins.
    for (int i = VOICES - 1; i >= 0; i--) begin
      if (!used[i]) begin
        found = 1'b1;
        idx   = IDX_W'(i);
      end
    end
  end

endmodule

// File: sv/vha_slot_mem.sv
// ----------------------------------------------------------------------------
// vha_slot_mem
// Generation and payload stores of the voice slots, with registered read data.
// ----------------------------------------------------------------------------
module vha_slot_mem #(
  parameter int VOICES   = 32,
  parameter int GEN_BITS = 24,
  parameter int IDX_W    = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  rd_en,
  input  logic [IDX_W-1:0]      rd_addr,
  input  vha_pkg::mem_we_t      we,
  input  logic [IDX_W-1:0]      wr_addr,
  input  logic [GEN_BITS-1:0]   gen_wdata,
  input  logic [31:0]           pay_wdata,
  output logic [GEN_BITS-1:0]   gen_rdata,
  output logic [31:0]           pay_rdata
);
  import vha_pkg::*;

  logic [GEN_BITS-1:0]  gen_mem [VOICES];
  logic [PAYLOAD_W-1:0] pay_mem [VOICES];
  logic [VOICES-1:0]    gen_valid;
  logic [GEN_BITS-1:0]  gen_q;
  logic                 gen_vld_q;

  // A generation entry never written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      gen_valid <= '0;
    end else if (we.gen_we) begin
      gen_valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we.gen_we) begin
      gen_mem[wr_addr] <= gen_wdata;
    end
    if (rd_en) begin
      gen_q     <= gen_mem[rd_addr];
      gen_vld_q <= gen_valid[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (we.pay_we) begin
      pay_mem[wr_addr] <= pay_wdata;
    end
    if (rd_en) begin
      pay_rdata <= pay_mem[rd_addr];
    end
  end

  assign gen_rdata = gen_vld_q ? gen_q : '0;

endmodule

// File: sv/voice_handle_allocator.sv
// ----------------------------------------------------------------------------
// voice_handle_allocator
// Generational slot map of voice slots handed out through 32-bit handles.
// ----------------------------------------------------------------------------
// Flow: a request is accepted in the idle state, reading the slot stores;
// the execute state, which waits while the previous response is unclaimed,
// writes them back. No request is taken until the last one has executed.
// Reset clears the used marks, the active count and the generation valid
// bits at once; the block is ready for a request as soon as reset is released.
// ----------------------------------------------------------------------------
module voice_handle_allocator #(
  parameter int VOICES   = 32,
  parameter int GEN_BITS = 24
) (
  input  logic      clk,
  input  logic      rst,
  vha_req_if.sink   req,
  vha_rsp_if.source rsp
);
  import vha_pkg::*;

  localparam int IDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  // Used marks live in flip-flops: the free-slot search needs all of them.
  logic [VOICES-1:0]   used;
  logic [ACTIVE_W-1:0] count;

  // Request captured at accept.
  kind_t               kind_q;
  logic [HANDLE_W-1:0] handle_q;
  logic [31:0]         pay_q;
  logic                src_q;
  logic [IDX_W-1:0]    addr_q;
  logic                addr_ok_q;

  // Output register.
  logic                out_valid;
  logic [HANDLE_W-1:0] new_handle;
  logic                ok;
  logic [31:0]         stored_payload;

  logic                   accept;
  logic                   go;
  logic                   free_found;
  logic [IDX_W-1:0]       free_idx;
  logic [SLOT_FIELD_W-1:0] hslot;
  logic                   h_ok;
  logic                   s_ok;
  logic [IDX_W-1:0]       addr;
  logic                   addr_ok;
  logic [GEN_BITS-1:0]    gen_rd;
  logic [31:0]            pay_rd;
  logic                   live;
  mem_we_t                we;
  logic                   set_used;
  logic                   clr_used;
  logic                   res_ok;
  logic [HANDLE_W-1:0]    res_handle;
  logic [31:0]            res_payload;
  logic [SLOT_FIELD_W-1:0] slot_plus1;

  vha_free_find #(
    .VOICES (VOICES),
    .IDX_W  (IDX_W)
  ) u_free_find (
    .used  (used),
    .found (free_found),
    .idx   (free_idx)
  );

  // Slot addressed by the incoming beat. A handle names slot (low byte - 1);
  // a low byte of zero never names a slot.
  assign hslot = req.handle[SLOT_FIELD_W-1:0] - SLOT_FIELD_W'(1);
  assign h_ok  = (req.handle[SLOT_FIELD_W-1:0] != '0) &&
                 (hslot < SLOT_FIELD_W'(VOICES));
  assign s_ok  = req.slot_index < SLOT_FIELD_W'(VOICES);

  always_comb begin
    addr    = hslot[IDX_W-1:0];
    addr_ok = h_ok;
    unique case (kind_t'(req.kind))
      KIND_PLAY: begin
        addr    = free_idx;
        addr_ok = free_found;
      end
      KIND_RELEASE: begin
        addr    = req.slot_index[IDX_W-1:0];
        addr_ok = s_ok;
      end
      default: ;
    endcase
  end

  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  // The execute cycle waits while the previous result is still unclaimed.
  assign go        = (state == ST_EXEC) && (!out_valid || rsp.ready);

  vha_slot_mem #(
    .VOICES   (VOICES),
    .GEN_BITS (GEN_BITS),
    .IDX_W    (IDX_W)
  ) u_slot_mem (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (accept),
    .rd_addr   (addr),
    .we        (we),
    .wr_addr   (addr_q),
    .gen_wdata (gen_rd + GEN_BITS'(1)),
    .pay_wdata (pay_q),
    .gen_rdata (gen_rd),
    .pay_rdata (pay_rd)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q    <= kind_t'(req.kind);
      handle_q  <= req.handle;
      pay_q     <= req.payload;
      src_q     <= req.source_ready;
      addr_q    <= addr;
      addr_ok_q <= addr_ok;
    end
  end

  // A handle is live when its slot is in use and its upper bits match the
  // stored generation exactly, including the bits above the generation width.
  assign live = addr_ok_q && used[addr_q] &&
                (handle_q[HANDLE_W-1:SLOT_FIELD_W] == HGEN_W'(gen_rd));

  assign slot_plus1 = SLOT_FIELD_W'(addr_q) + SLOT_FIELD_W'(1);

  always_comb begin
    we          = '0;
    set_used    = 1'b0;
    clr_used    = 1'b0;
    res_ok      = 1'b0;
    res_handle  = '0;
    res_payload = '0;
    unique case (kind_q)
      KIND_PLAY: begin
        if (src_q && addr_ok_q) begin
          set_used   = 1'b1;
          we.pay_we  = 1'b1;
          res_ok     = 1'b1;
          res_handle = {HGEN_W'(gen_rd), slot_plus1};
        end
      end
      KIND_STOP: begin
        if (live) begin
          clr_used  = 1'b1;
          we.gen_we = 1'b1;
          res_ok    = 1'b1;
        end
      end
      KIND_QUERY: begin
        if (live) begin
          res_ok      = 1'b1;
          res_payload = pay_rd;
        end
      end
      KIND_UPDATE: begin
        if (live) begin
          we.pay_we = 1'b1;
          res_ok    = 1'b1;
        end
      end
      KIND_RELEASE: begin
        if (addr_ok_q && used[addr_q]) begin
          clr_used  = 1'b1;
          we.gen_we = 1'b1;
          res_ok    = 1'b1;
        end
      end
      default: ;
    endcase
    if (!go) begin
      we       = '0;
      set_used = 1'b0;
      clr_used = 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept) state_next = ST_EXEC;
      ST_EXEC: if (go) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      used      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (set_used) begin
        used[addr_q] <= 1'b1;
        count        <= count + ACTIVE_W'(1);
      end else if (clr_used) begin
        used[addr_q] <= 1'b0;
        count        <= count - ACTIVE_W'(1);
      end
      if (go) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // The count reported is the one after this operation.
  always_ff @(posedge clk) begin
    if (go) begin
      new_handle         <= res_handle;
      ok                 <= res_ok;
      stored_payload     <= res_payload;
      rsp.active_count   <= set_used ? count + ACTIVE_W'(1) :
                            clr_used ? count - ACTIVE_W'(1) : count;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.new_handle     = new_handle;
  assign rsp.ok             = ok;
  assign rsp.stored_payload = stored_payload;

endmodule
